FILE: src/pressure_average_scale_hysteresis_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef PRESSURE_AVERAGE_SCALE_HYSTERESIS_MACROS_SVH
`define PRESSURE_AVERAGE_SCALE_HYSTERESIS_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define PASH_ASSERT_NOW(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pash: invariant violated");

// Same-cycle implication.
`define PASH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pash: implication violated");

`endif

FILE: src/pash_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pash_pkg;

    localparam int WINDOW_LOG2_DEF = 7;
    localparam int DATA_W          = 16;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int QUEUE_DEPTH     = 2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_POINT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_GAIN       = 3'd5;

    // Config reset values
    localparam logic [31:0] SET_POINT_RST       = 32'd43737400;
    localparam logic [31:0] HYSTERESIS_RST      = 32'd500000;
    localparam logic [15:0] PRESSURE_OFFSET_RST = 16'd1638;
    localparam logic [15:0] PRESSURE_GAIN_RST   = 16'd4577;
    localparam logic [15:0] TEMP_OFFSET_RST     = 16'd16383;
    localparam logic [15:0] TEMP_GAIN_RST       = 16'd3051;

    // Low temperature bits that carry no information
    localparam logic [15:0] TEMP_DROP_MASK = 16'h001F;

    typedef struct packed {
        logic [31:0] set_point;
        logic [31:0] hysteresis;
        logic [15:0] pressure_offset;
        logic [15:0] pressure_gain;
        logic [15:0] temp_offset;
        logic [15:0] temp_gain;
    } t_cfg;

    // Queue entry: averaged pressure and offset temperature
    typedef struct packed {
        logic [15:0] avg;
        logic [15:0] temp;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

FILE: src/pash_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pash_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/pash_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pash_front import pash_pkg::*; #(
    parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [DATA_W-1:0] i_pressure_raw,
    input  wire logic [DATA_W-1:0] i_temp_raw,
    input  wire t_cfg              i_cfg,
    input  wire t_queue_status     i_queue_status,
    output logic                   o_ready,
    output logic                   o_push,
    output t_item                  o_item
);

    localparam int SUM_W = DATA_W + WINDOW_LOG2;
    localparam int DEPTH = 1 << WINDOW_LOG2;

    logic [WINDOW_LOG2-1:0] r_idx, n_idx;
    logic                   r_wrapped, n_wrapped;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [DATA_W-1:0]      ram_rdata;
    logic [DATA_W-1:0]      old_sample;
    logic [DATA_W-1:0]      sample;
    logic                   accept;

    assign o_ready = !i_queue_status.full;
    assign accept  = i_valid && o_ready;

    assign sample = i_pressure_raw - i_cfg.pressure_offset;
    // Until the ring has wrapped once, the entry at the write index is unwritten and counts as zero.
    assign old_sample = r_wrapped ? ram_rdata : '0;

    always_comb begin
        n_idx     = r_idx;
        n_wrapped = r_wrapped;
        n_sum     = r_sum;
        if (accept) begin
            n_idx = r_idx + 1'b1;
            if (&r_idx) begin
                n_wrapped = 1'b1;
            end
            n_sum = r_sum - SUM_W'(old_sample) + SUM_W'(sample);
        end
    end

    // Read address runs one step ahead so the old entry is ready at accept.
    pash_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_idx),
        .i_wdata (sample),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
        end else begin
            r_idx     <= n_idx;
            r_wrapped <= n_wrapped;
            r_sum     <= n_sum;
        end
    end

    assign o_push      = accept;
    assign o_item.avg  = n_sum[SUM_W-1:WINDOW_LOG2];
    assign o_item.temp = (i_temp_raw & ~TEMP_DROP_MASK) - i_cfg.temp_offset;

endmodule

`default_nettype wire

FILE: src/pash_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module pash_fifo import pash_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_item   i_item,
    input  wire logic    i_pop,
    output t_item        o_item,
    output t_queue_status o_status
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    t_item             r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [COUNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_status.full  = (r_count == COUNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_item         = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/pash_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pash_back import pash_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_item  i_item,
    input  wire logic   i_item_valid,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_ready,
    output logic        o_pop,
    output logic        o_valid,
    output logic [31:0] o_pressure_scaled,
    output logic signed [31:0] o_temp_scaled,
    output logic        o_drive_on
);

    logic               r_m_valid;
    logic [31:0]        r_m_press;
    logic [31:0]        r_m_temp;
    logic               r_o_valid;
    logic [31:0]        r_o_press;
    logic signed [31:0] r_o_temp;
    logic               r_drive, n_drive;
    logic               adv_o, adv_m;
    logic signed [31:0] prod_press, prod_temp;
    logic [31:0]        low_edge;

    assign adv_o = !r_o_valid || i_ready;
    assign adv_m = !r_m_valid || adv_o;
    assign o_pop = i_item_valid && adv_m;

    assign prod_press = $signed(i_item.avg) * $signed(i_cfg.pressure_gain);
    assign prod_temp  = $signed(i_item.temp) * $signed(i_cfg.temp_gain);

    // Lower edge of the band wraps modulo 2^32
    assign low_edge = i_cfg.set_point - i_cfg.hysteresis;

    always_comb begin
        n_drive = r_drive;
        if (r_m_press >= i_cfg.set_point) begin
            n_drive = 1'b0;
        end else if (r_m_press <= low_edge) begin
            n_drive = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_drive   <= 1'b0;
        end else begin
            if (adv_m) begin
                r_m_valid <= i_item_valid;
            end
            if (adv_o) begin
                r_o_valid <= r_m_valid;
                if (r_m_valid) begin
                    r_drive <= n_drive;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_press <= prod_press;
            r_m_temp  <= prod_temp;
        end
        if (adv_o && r_m_valid) begin
            r_o_press <= r_m_press;
            r_o_temp  <= r_m_temp;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_pressure_scaled = r_o_press;
    assign o_temp_scaled     = r_o_temp;
    assign o_drive_on        = r_drive;

endmodule

`default_nettype wire

FILE: src/pressure_average_scale_hysteresis.sv
// Pressure moving average, gain scaling and valve hysteresis.
// Input channel: i_valid / o_ready carry one item (raw pressure, raw temperature).
// Output channel: o_valid / i_ready carry one result item per input item, in order:
//   scaled pressure average, scaled temperature and the valve drive level.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_index in the cycle it is high;
//   indexes 6 and 7 are ignored. Write only while no item is in flight.
// Pipeline: the queue is written at the accepting edge, then the multiply stage,
//   then the output register.
// Throughput: one item per cycle while the queue is not full; the ring is read one
//   index ahead via its registered read port, so the sum's read-modify-write never stalls.
// Reset (synchronous, low): config back to defaults, ring counted as all zero
//   (no clearing pass; unwritten entries read as zero until the ring wraps),
//   running sum zero, drive off, queue and pipeline empty.
// Output stall: results hold in the output register; the multiply stage and a
//   two-entry queue behind it keep accepting until the queue fills, then o_ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "pressure_average_scale_hysteresis_macros.svh"

module pressure_average_scale_hysteresis import pash_pkg::*; #(
    parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [DATA_W-1:0]    i_pressure_raw,
    input  wire logic [DATA_W-1:0]    i_temp_raw,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [31:0]               o_pressure_scaled,
    output logic signed [31:0]        o_temp_scaled,
    output logic                      o_drive_on,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int INFLIGHT_MAX = QUEUE_DEPTH + 2;
    localparam int INFLIGHT_W   = $clog2(INFLIGHT_MAX + 1);
    localparam logic [INFLIGHT_W-1:0] FULL_MIN = INFLIGHT_W'(QUEUE_DEPTH);

    t_cfg          r_cfg;
    t_item         front_item;
    t_item         queue_item;
    t_queue_status q_status;
    logic          q_push;
    logic          q_pop;
    logic          in_acc, out_acc;
    logic [INFLIGHT_W-1:0] r_inflight;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_point       <= SET_POINT_RST;
            r_cfg.hysteresis      <= HYSTERESIS_RST;
            r_cfg.pressure_offset <= PRESSURE_OFFSET_RST;
            r_cfg.pressure_gain   <= PRESSURE_GAIN_RST;
            r_cfg.temp_offset     <= TEMP_OFFSET_RST;
            r_cfg.temp_gain       <= TEMP_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SET_POINT:       r_cfg.set_point       <= i_cfg_data;
                CFG_HYSTERESIS:      r_cfg.hysteresis      <= i_cfg_data;
                CFG_PRESSURE_OFFSET: r_cfg.pressure_offset <= i_cfg_data[15:0];
                CFG_PRESSURE_GAIN:   r_cfg.pressure_gain   <= i_cfg_data[15:0];
                CFG_TEMP_OFFSET:     r_cfg.temp_offset     <= i_cfg_data[15:0];
                CFG_TEMP_GAIN:       r_cfg.temp_gain       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Front: offset, ring update, running sum, temperature prep
    pash_front #(
        .WINDOW_LOG2 (WINDOW_LOG2)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_pressure_raw (i_pressure_raw),
        .i_temp_raw     (i_temp_raw),
        .i_cfg          (r_cfg),
        .i_queue_status (q_status),
        .o_ready        (o_ready),
        .o_push         (q_push),
        .o_item         (front_item)
    );

    // Decoupling queue between front and back
    pash_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (front_item),
        .i_pop    (q_pop),
        .o_item   (queue_item),
        .o_status (q_status)
    );

    // Back: gain multiplies, hysteresis, output register
    pash_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (queue_item),
        .i_item_valid      (!q_status.empty),
        .i_cfg             (r_cfg),
        .i_ready           (i_ready),
        .o_pop             (q_pop),
        .o_valid           (o_valid),
        .o_pressure_scaled (o_pressure_scaled),
        .o_temp_scaled     (o_temp_scaled),
        .o_drive_on        (o_drive_on)
    );

    // Items accepted but not yet delivered
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_acc && !out_acc) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    `PASH_ASSERT_NOW(a_inflight_bound, i_clk, i_rst_n, r_inflight <= INFLIGHT_W'(INFLIGHT_MAX))
    `PASH_ASSERT_IMP(a_out_has_item, i_clk, i_rst_n, o_valid, r_inflight != '0)
    `PASH_ASSERT_IMP(a_full_queue_count, i_clk, i_rst_n, q_status.full, r_inflight >= FULL_MIN)

endmodule

`default_nettype wire

FILE: bench/pash_result_checker.sv
`timescale 1ns / 1ps

// Watches both item channels and the register port, predicts each result item
// from the accepted input items and compares it field by field.
module pash_result_checker import pash_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [DATA_W-1:0]    i_pressure_raw,
    input  logic [DATA_W-1:0]    i_temp_raw,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [31:0]          i_pressure_scaled,
    input  logic signed [31:0]   i_temp_scaled,
    input  logic                 i_drive_on,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    localparam int RING_DEPTH = 1 << WINDOW_LOG2_DEF;
    localparam int SUM_W      = DATA_W + WINDOW_LOG2_DEF;

    typedef struct packed {
        logic [31:0] pressure_scaled;
        logic [31:0] temp_scaled;
        logic        drive_on;
    } t_reading;

    t_cfg                       regs;
    logic [DATA_W-1:0]          sample_ring [0:RING_DEPTH-1];
    logic [WINDOW_LOG2_DEF-1:0] wr_ptr;
    logic [SUM_W-1:0]           window_sum;
    logic                       valve_on;
    t_reading                   pending_readings [$];
    int                         mismatch_count = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // Advances the filter state by one sample and returns the result item.
    function automatic t_reading predict_reading(input logic [DATA_W-1:0] p_raw,
                                                 input logic [DATA_W-1:0] t_raw);
        logic [DATA_W-1:0]  p_adj;
        logic [DATA_W-1:0]  t_adj;
        logic [DATA_W-1:0]  avg;
        logic signed [31:0] p_prod;
        logic signed [31:0] t_prod;
        logic [31:0]        low_edge;
        t_reading           r;
        p_adj = p_raw - regs.pressure_offset;
        window_sum = window_sum - sample_ring[wr_ptr] + p_adj;
        sample_ring[wr_ptr] = p_adj;
        wr_ptr = wr_ptr + 1'b1;
        avg = window_sum[SUM_W-1:WINDOW_LOG2_DEF];
        p_prod = $signed(avg) * $signed(regs.pressure_gain);

        t_adj = (t_raw & ~TEMP_DROP_MASK) - regs.temp_offset;
        t_prod = $signed(t_adj) * $signed(regs.temp_gain);

        // unsigned compare on the raw pattern; low edge may wrap
        low_edge = regs.set_point - regs.hysteresis;
        if (32'(p_prod) >= regs.set_point) begin
            valve_on = 1'b0;
        end else if (32'(p_prod) <= low_edge) begin
            valve_on = 1'b1;
        end

        r.pressure_scaled = p_prod;
        r.temp_scaled     = t_prod;
        r.drive_on        = valve_on;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reading want;
        if (!i_rst_n) begin
            regs.set_point       = SET_POINT_RST;
            regs.hysteresis      = HYSTERESIS_RST;
            regs.pressure_offset = PRESSURE_OFFSET_RST;
            regs.pressure_gain   = PRESSURE_GAIN_RST;
            regs.temp_offset     = TEMP_OFFSET_RST;
            regs.temp_gain       = TEMP_GAIN_RST;
            for (int k = 0; k < RING_DEPTH; k++) begin
                sample_ring[k] = '0;
            end
            wr_ptr     = '0;
            window_sum = '0;
            valve_on   = 1'b0;
            pending_readings.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_readings.size() == 0) begin
                    $display("%0t: unexpected item: pressure %h temp %0d drive %b",
                             $time, i_pressure_scaled, i_temp_scaled, i_drive_on);
                    mismatch_count++;
                end else begin
                    want = pending_readings.pop_front();
                    if (i_pressure_scaled !== want.pressure_scaled) begin
                        $display("%0t: pressure_scaled expected %h, got %h",
                                 $time, want.pressure_scaled, i_pressure_scaled);
                        mismatch_count++;
                    end
                    if (i_temp_scaled !== want.temp_scaled) begin
                        $display("%0t: temp_scaled expected %0d, got %0d",
                                 $time, $signed(want.temp_scaled), i_temp_scaled);
                        mismatch_count++;
                    end
                    if (i_drive_on !== want.drive_on) begin
                        $display("%0t: drive_on expected %b, got %b",
                                 $time, want.drive_on, i_drive_on);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SET_POINT:       regs.set_point       = i_cfg_data;
                    CFG_HYSTERESIS:      regs.hysteresis      = i_cfg_data;
                    CFG_PRESSURE_OFFSET: regs.pressure_offset = i_cfg_data[15:0];
                    CFG_PRESSURE_GAIN:   regs.pressure_gain   = i_cfg_data[15:0];
                    CFG_TEMP_OFFSET:     regs.temp_offset     = i_cfg_data[15:0];
                    CFG_TEMP_GAIN:       regs.temp_gain       = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                pending_readings.push_back(predict_reading(i_pressure_raw, i_temp_raw));
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= pending_readings.size();
    end

endmodule

FILE: bench/pressure_average_scale_hysteresis_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the pressure filter. All checking lives in
// pash_result_checker, which sits beside the block and reports a mismatch count
// and the number of result items still owed.
module pressure_average_scale_hysteresis_tb;
    import pash_pkg::*;

    // Far above the slowest legal run: ~950 items, each with a possible sender gap
    // and receiver stalls, plus register phases and drains.
    localparam int CYCLE_LIMIT  = 200000;
    // Pipeline is 3 deep; let a few more edges pass before touching registers.
    localparam int SETTLE_TICKS = 8;

    // Indexes past the last register; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic                   o_ready;
    logic [DATA_W-1:0]      i_pressure_raw = '0;
    logic [DATA_W-1:0]      i_temp_raw     = '0;
    logic                   o_valid;
    logic                   i_ready        = 1'b0;
    logic [31:0]            o_pressure_scaled;
    logic signed [31:0]     o_temp_scaled;
    logic                   o_drive_on;
    logic                   i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index    = '0;
    logic [CFG_W-1:0]       i_cfg_data     = '0;

    int mismatches;
    int outstanding;
    int cycles      = 0;
    int stall_left  = 0;
    bit send_gaps   = 1'b0;   // sender inserts idle bursts
    bit sink_stalls = 1'b0;   // receiver drops ready in bursts

    pressure_average_scale_hysteresis dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pressure_raw    (i_pressure_raw),
        .i_temp_raw        (i_temp_raw),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pressure_scaled (o_pressure_scaled),
        .o_temp_scaled     (o_temp_scaled),
        .o_drive_on        (o_drive_on),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    pash_result_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_pressure_raw    (i_pressure_raw),
        .i_temp_raw        (i_temp_raw),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_pressure_scaled (o_pressure_scaled),
        .i_temp_scaled     (o_temp_scaled),
        .i_drive_on        (o_drive_on),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("pressure_average_scale_hysteresis_tb: errors");
            $finish;
        end
    end

    // Receiver: ready drops in bursts while stalls are enabled.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Offers one item and returns right after the edge that accepts it. Valid is
    // left high so back-to-back items need no second assignment in one step.
    task automatic send_sample(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] t);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pressure_raw <= p;
        i_temp_raw     <= t;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Holds the sender until every owed result item has come back, then lets the
    // pipeline settle. The first edge lets the checker log the last accept.
    task automatic drain_pipeline;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Writes all six registers. Narrow registers get junk in the upper half,
    // and the spare indexes are hit last so an aliased decode shows up.
    task automatic program_regs(input logic [31:0] sp, input logic [31:0] hy,
                                input logic [15:0] p_off, input logic [15:0] p_gain,
                                input logic [15:0] t_off, input logic [15:0] t_gain);
        put_reg(CFG_SET_POINT, sp);
        put_reg(CFG_HYSTERESIS, hy);
        put_reg(CFG_PRESSURE_OFFSET, {16'($urandom), p_off});
        put_reg(CFG_PRESSURE_GAIN, {16'($urandom), p_gain});
        put_reg(CFG_TEMP_OFFSET, {16'($urandom), t_off});
        put_reg(CFG_TEMP_GAIN, {16'($urandom), t_gain});
        put_reg(CFG_SPARE_A, $urandom);
        put_reg(CFG_SPARE_B, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // One random phase. Tracking mode places the hysteresis band on the scaled
    // average between two levels and then swings the pressure between a level
    // below the band and one above it, so the average crosses the band slowly:
    // off at set point, on at the low edge, hold in between. Other modes use
    // negative gains, a wrapping low edge or fully random registers.
    // About one item in five is raw noise.
    task automatic random_phase(input int n_items, input bit tracking);
        logic [15:0] p_off;
        logic [15:0] p_gain;
        logic [15:0] band_lo;
        logic [15:0] band_hi;
        logic [15:0] level;
        logic [31:0] sp;
        logic [31:0] hy;
        int          seg_left;
        bit          go_high;
        p_off   = $urandom;
        band_hi = $urandom_range(64, 32767);
        band_lo = $urandom_range(0, band_hi - 1);
        if (tracking) begin
            p_gain = $urandom_range(1, 32767);
            sp     = 32'(band_hi) * 32'(p_gain);
            hy     = 32'(band_hi - band_lo) * 32'(p_gain);
        end else if ($urandom_range(0, 1) == 0) begin
            // negative gain and a band wider than the set point
            p_gain = $urandom_range(32768, 65535);
            sp     = $urandom;
            hy     = sp + 32'($urandom_range(1, 32'h7FFF_FFFF));
        end else begin
            p_gain = $urandom;
            sp     = $urandom;
            hy     = $urandom;
        end
        program_regs(sp, hy, p_off, p_gain, 16'($urandom), 16'($urandom));

        seg_left = 0;
        go_high  = $urandom_range(0, 1);
        level    = '0;
        for (int n = 0; n < n_items; n++) begin
            if (seg_left == 0) begin
                go_high  = !go_high;
                level    = go_high ? 16'($urandom_range(band_hi, 65535))
                                   : 16'($urandom_range(0, band_lo));
                seg_left = $urandom_range(40, 160);
            end
            seg_left--;
            if ($urandom_range(0, 4) == 0) begin
                send_sample(16'($urandom), 16'($urandom));
            end else begin
                send_sample(p_off + level + 16'($urandom_range(0, 31)) - 16'd16,
                            16'($urandom));
            end
        end
        drain_pipeline();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset register values: field extremes, pressure equal to
        // and just under its offset, temperature low bits only, sign bits.
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'hFFFF, 16'h0000);
        send_sample(PRESSURE_OFFSET_RST, TEMP_DROP_MASK);
        send_sample(PRESSURE_OFFSET_RST - 16'd1, ~TEMP_DROP_MASK);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);
        drain_pipeline();

        // Zero set point with the widest band, all-ones offsets, most
        // negative pressure gain and most positive temperature gain.
        program_regs(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h7FFF);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h8000, 16'h001F);
        send_sample(16'h7FFF, 16'hFFE0);
        send_sample(16'hFFFF, 16'h8000);
        send_sample(16'h0001, 16'h7FFF);
        drain_pipeline();

        // All-ones set point with no band, zero offsets, gains flipped.
        program_regs(32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h8000);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h001F);
        send_sample(16'hFFFF, 16'hFFE0);
        send_sample(16'h1234, 16'hFEDC);
        drain_pipeline();

        // Random phases; idling on each side switched per phase so some phases
        // run flat out. Every phase ends with a full drain.
        for (int ph = 0; ph < 5; ph++) begin
            send_gaps   = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
            random_phase(150, ph == 0 || $urandom_range(0, 2) != 0);
        end

        // Last stretch without any idling.
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
        random_phase(150, 1'b1);

        if (mismatches == 0 && outstanding == 0) begin
            $display("pressure_average_scale_hysteresis_tb: clean");
        end else begin
            $display("pressure_average_scale_hysteresis_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/pash_pkg.sv
src/pash_ram.sv
src/pash_front.sv
src/pash_fifo.sv
src/pash_back.sv
src/pressure_average_scale_hysteresis.sv
bench/pash_result_checker.sv
bench/pressure_average_scale_hysteresis_tb.sv
